@@ design/gfrm_pkg.sv @@
package gfrm_pkg;

    localparam int FIELD_BITS = 64;
    localparam int MULT_BITS  = 32;
    localparam int STEP_BITS  = 8;
    localparam int NUM_STAGES = MULT_BITS / STEP_BITS;

    localparam logic [3:0]  POLY_W4  = 4'h3;
    localparam logic [7:0]  POLY_W8  = 8'h1d;
    localparam logic [15:0] POLY_W16 = 16'h100b;
    localparam logic [31:0] POLY_W32 = 32'h0040_0007;

    typedef enum logic [1:0] {
        MODE_W4  = 2'd0,
        MODE_W8  = 2'd1,
        MODE_W16 = 2'd2,
        MODE_W32 = 2'd3
    } mode_t;

    localparam logic [1:0] CFG_WIDTH_MODE = 2'd0;
    localparam logic [1:0] CFG_MULTIPLIER = 2'd1;
    localparam logic [1:0] CFG_ACCUMULATE = 2'd2;

    typedef struct packed {
        logic [63:0] src_word;
        logic [63:0] dst_word;
        logic        last_in;
    } req_t;

    typedef struct packed {
        logic [63:0] out_word;
        logic        last_out;
    } rsp_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] acc;
        logic [FIELD_BITS-1:0] src;
        logic [FIELD_BITS-1:0] dst;
        logic                  last;
    } stage_t;

    // lane-wise multiply by x, reduced by the primitive polynomial of the width
    function automatic logic [FIELD_BITS-1:0] xtime(logic [FIELD_BITS-1:0] x, mode_t mode);
        logic [FIELD_BITS-1:0] r;
        r = '0;
        case (mode)
            MODE_W4:
            begin
                for (int i = 0; i < FIELD_BITS / 4; i++)
                begin
                    r[4*i +: 4] = {x[4*i +: 3], 1'b0} ^ (x[4*i+3] ? POLY_W4 : 4'h0);
                end
            end
            MODE_W8:
            begin
                for (int i = 0; i < FIELD_BITS / 8; i++)
                begin
                    r[8*i +: 8] = {x[8*i +: 7], 1'b0} ^ (x[8*i+7] ? POLY_W8 : 8'h0);
                end
            end
            MODE_W16:
            begin
                for (int i = 0; i < FIELD_BITS / 16; i++)
                begin
                    r[16*i +: 16] = {x[16*i +: 15], 1'b0}
                                    ^ (x[16*i+15] ? POLY_W16 : 16'h0);
                end
            end
            MODE_W32:
            begin
                for (int i = 0; i < FIELD_BITS / 32; i++)
                begin
                    r[32*i +: 32] = {x[32*i +: 31], 1'b0}
                                    ^ (x[32*i+31] ? POLY_W32 : 32'h0);
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

@@ design/gfrm_stage.sv @@
module gfrm_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                up_valid,
    output logic                                up_ready,
    input  gfrm_pkg::stage_t                    up,
    output logic                                dn_valid,
    input  logic                                dn_ready,
    output gfrm_pkg::stage_t                    dn,
    input  gfrm_pkg::mode_t                     mode,
    input  logic [gfrm_pkg::STEP_BITS-1:0]      mbits,
    input  logic                                fold_dst
);

    logic                              valid_reg;
    gfrm_pkg::stage_t                  data_reg;
    gfrm_pkg::stage_t                  data_next;
    logic [gfrm_pkg::FIELD_BITS-1:0]   acc;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = data_reg;

    // horner steps, multiplier bits msb first
    always_comb
    begin
        acc = up.acc;
        for (int i = gfrm_pkg::STEP_BITS - 1; i >= 0; i--)
        begin
            acc = gfrm_pkg::xtime(acc, mode) ^ (mbits[i] ? up.src : '0);
        end
        data_next      = up;
        data_next.acc  = acc ^ (fold_dst ? up.dst : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ design/gf_region_const_multiply.sv @@
// throughput: one 64-bit word per cycle, a new request every cycle when unstalled
// four register stages, each doing 8 horner steps of the 32-bit aligned multiplier
// reset clears all stage valid bits and sets width_mode to w8, multiplier to 1,
// accumulate off; stage payload registers are not reset
module gf_region_const_multiply #(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  gfrm_pkg::req_t       req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output gfrm_pkg::rsp_t       rsp
);

    localparam int ACTIVE_BITS = (WORD_BITS < gfrm_pkg::FIELD_BITS) ?
                                 WORD_BITS : gfrm_pkg::FIELD_BITS;
    localparam int LANE_BITS_W4  = (ACTIVE_BITS / 4) * 4;
    localparam int LANE_BITS_W8  = (ACTIVE_BITS / 8) * 8;
    localparam int LANE_BITS_W16 = (ACTIVE_BITS / 16) * 16;
    localparam int LANE_BITS_W32 = (ACTIVE_BITS / 32) * 32;
    localparam logic [gfrm_pkg::FIELD_BITS-1:0] MASK_W4  =
        {gfrm_pkg::FIELD_BITS{1'b1}} >> (gfrm_pkg::FIELD_BITS - LANE_BITS_W4);
    localparam logic [gfrm_pkg::FIELD_BITS-1:0] MASK_W8  =
        {gfrm_pkg::FIELD_BITS{1'b1}} >> (gfrm_pkg::FIELD_BITS - LANE_BITS_W8);
    localparam logic [gfrm_pkg::FIELD_BITS-1:0] MASK_W16 =
        {gfrm_pkg::FIELD_BITS{1'b1}} >> (gfrm_pkg::FIELD_BITS - LANE_BITS_W16);
    localparam logic [gfrm_pkg::FIELD_BITS-1:0] MASK_W32 =
        {gfrm_pkg::FIELD_BITS{1'b1}} >> (gfrm_pkg::FIELD_BITS - LANE_BITS_W32);

    gfrm_pkg::mode_t                    width_mode_reg;
    logic [gfrm_pkg::MULT_BITS-1:0]     multiplier_reg;
    logic                               accumulate_reg;

    logic [gfrm_pkg::MULT_BITS-1:0]     mult_aligned;
    logic [gfrm_pkg::FIELD_BITS-1:0]    lane_mask;

    logic                               stg_valid [gfrm_pkg::NUM_STAGES+1];
    logic                               stg_ready [gfrm_pkg::NUM_STAGES+1];
    gfrm_pkg::stage_t                   stg_data  [gfrm_pkg::NUM_STAGES+1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_mode_reg <= gfrm_pkg::MODE_W8;
            multiplier_reg <= gfrm_pkg::MULT_BITS'(1);
            accumulate_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gfrm_pkg::CFG_WIDTH_MODE: width_mode_reg <= gfrm_pkg::mode_t'(cfg_data[1:0]);
                gfrm_pkg::CFG_MULTIPLIER: multiplier_reg <= cfg_data;
                gfrm_pkg::CFG_ACCUMULATE: accumulate_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // multiplier zero-extended to 32 bits, leading zero steps keep the accumulator at zero
    always_comb
    begin
        unique case (width_mode_reg)
            gfrm_pkg::MODE_W4:
            begin
                mult_aligned = {28'd0, multiplier_reg[3:0]};
                lane_mask    = MASK_W4;
            end
            gfrm_pkg::MODE_W8:
            begin
                mult_aligned = {24'd0, multiplier_reg[7:0]};
                lane_mask    = MASK_W8;
            end
            gfrm_pkg::MODE_W16:
            begin
                mult_aligned = {16'd0, multiplier_reg[15:0]};
                lane_mask    = MASK_W16;
            end
            gfrm_pkg::MODE_W32:
            begin
                mult_aligned = multiplier_reg;
                lane_mask    = MASK_W32;
            end
            default:
            begin
                mult_aligned = '0;
                lane_mask    = '0;
            end
        endcase
    end

    assign stg_valid[0]     = req_valid;
    assign stg_data[0].acc  = '0;
    assign stg_data[0].src  = req.src_word & lane_mask;
    assign stg_data[0].dst  = req.dst_word;
    assign stg_data[0].last = req.last_in;
    assign req_stall        = !stg_ready[0];

    for (genvar k = 0; k < gfrm_pkg::NUM_STAGES; k++)
    begin : g_stage
        gfrm_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[k]),
            .up_ready (stg_ready[k]),
            .up       (stg_data[k]),
            .dn_valid (stg_valid[k+1]),
            .dn_ready (stg_ready[k+1]),
            .dn       (stg_data[k+1]),
            .mode     (width_mode_reg),
            .mbits    (mult_aligned[gfrm_pkg::MULT_BITS-1-k*gfrm_pkg::STEP_BITS -:
                                    gfrm_pkg::STEP_BITS]),
            .fold_dst ((k == gfrm_pkg::NUM_STAGES - 1) ? accumulate_reg : 1'b0)
        );
    end

    assign stg_ready[gfrm_pkg::NUM_STAGES] = !rsp_stall;
    assign rsp_valid    = stg_valid[gfrm_pkg::NUM_STAGES];
    assign rsp.out_word = stg_data[gfrm_pkg::NUM_STAGES].acc;
    assign rsp.last_out = stg_data[gfrm_pkg::NUM_STAGES].last;

`ifndef SYNTHESIS
    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> stg_valid[1])
        else $error("accepted transaction missing from first stage");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> stg_valid[1])
        else $error("request stalled with empty first stage");

    a_free_output_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_stall |-> !req_stall)
        else $error("request stalled while response side is free");

    a_last_stage_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid[gfrm_pkg::NUM_STAGES-1] && stg_ready[gfrm_pkg::NUM_STAGES-1]
        |=> rsp_valid)
        else $error("transaction lost entering output stage");
`endif

endmodule

@@ tb/gf_region_const_multiply_tb.sv @@
`timescale 1ns / 1ps

module gf_region_const_multiply_tb;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          NUM_PHASES   = 12;
    localparam int          PHASE_ITEMS  = 46;
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;

    class gf_product_scoreboard;
        gfrm_pkg::mode_t  width_mode;
        logic [31:0]      multiplier;
        logic             accumulate;
        gfrm_pkg::rsp_t   expected_words[$];
        int               errors;

        function new();
            width_mode = gfrm_pkg::MODE_W8;
            multiplier = 32'd1;
            accumulate = 1'b0;
            errors     = 0;
        endfunction

        function void set_config(gfrm_pkg::mode_t mode, logic [31:0] mult, logic acc);
            width_mode = mode;
            multiplier = mult;
            accumulate = acc;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // horner multiply of one lane, reducing by the field polynomial on each doubling
        function logic [31:0] lane_product(logic [31:0] a, logic [31:0] m, int w,
                                           logic [31:0] poly);
            logic [31:0] acc;
            logic [31:0] lmask;
            logic        hi;
            lmask = (w == 32) ? 32'hffff_ffff : ((32'd1 << w) - 32'd1);
            acc = '0;
            for (int k = w; k > 0; k--)
            begin
                hi = acc[w-1];
                acc = (acc << 1) & lmask;
                if (hi)
                    acc ^= poly;
                if (m[k-1])
                    acc ^= a;
            end
            return acc & lmask;
        endfunction

        function void note_request(gfrm_pkg::req_t r);
            int              w;
            logic [31:0]     poly;
            logic [31:0]     lmask;
            logic [31:0]     lane;
            logic [63:0]     prod;
            gfrm_pkg::rsp_t  e;
            case (width_mode)
                gfrm_pkg::MODE_W4:
                begin
                    w = 4;
                    poly = 32'(gfrm_pkg::POLY_W4);
                end
                gfrm_pkg::MODE_W8:
                begin
                    w = 8;
                    poly = 32'(gfrm_pkg::POLY_W8);
                end
                gfrm_pkg::MODE_W16:
                begin
                    w = 16;
                    poly = 32'(gfrm_pkg::POLY_W16);
                end
                default:
                begin
                    w = 32;
                    poly = 32'(gfrm_pkg::POLY_W32);
                end
            endcase
            lmask = (w == 32) ? 32'hffff_ffff : ((32'd1 << w) - 32'd1);
            prod = '0;
            for (int pos = 0; pos + w <= 64; pos += w)
            begin
                lane = 32'(r.src_word >> pos) & lmask;
                prod |= 64'(lane_product(lane, multiplier & lmask, w, poly)) << pos;
            end
            e.out_word = accumulate ? (prod ^ r.dst_word) : prod;
            e.last_out = r.last_in;
            expected_words.push_back(e);
        endfunction

        function void check_response(gfrm_pkg::rsp_t got);
            gfrm_pkg::rsp_t e;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected response transaction, expected none, actual %h_%b",
                         $time, got.out_word, got.last_out);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            if (got.out_word !== e.out_word)
            begin
                $display("%0t: out_word mismatch, expected %h, actual %h",
                         $time, e.out_word, got.out_word);
                errors++;
            end
            if (got.last_out !== e.last_out)
            begin
                $display("%0t: last_out mismatch, expected %b, actual %b",
                         $time, e.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    logic [1:0]      cfg_index = gfrm_pkg::CFG_WIDTH_MODE;
    logic [31:0]     cfg_data = '0;
    logic            req_valid = 1'b0;
    logic            req_stall;
    gfrm_pkg::req_t  req = '0;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    gfrm_pkg::rsp_t  rsp;

    gf_product_scoreboard sb = new();

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_request = 1'b0;
    int cycle_count  = 0;

    gf_region_const_multiply DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
        end
    end

    // receiver: random stall bursts, or one long hold when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input gfrm_pkg::req_t r);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic configure(input gfrm_pkg::mode_t mode, input logic [31:0] mult,
                             input logic acc);
        logic [31:0] data;
        data = $urandom;
        data[1:0] = mode;
        cfg_we    <= 1'b1;
        cfg_index <= gfrm_pkg::CFG_WIDTH_MODE;
        cfg_data  <= data;
        @(posedge clk);
        cfg_index <= gfrm_pkg::CFG_MULTIPLIER;
        cfg_data  <= mult;
        @(posedge clk);
        data = $urandom;
        data[0] = acc;
        cfg_index <= gfrm_pkg::CFG_ACCUMULATE;
        cfg_data  <= data;
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_config(mode, mult, acc);
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] rand_multiplier();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hffff_ffff;
            3: return 32'($urandom_range(2, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic gfrm_pkg::req_t rand_request();
        gfrm_pkg::req_t r;
        r.src_word = rand_word();
        r.dst_word = rand_word();
        r.last_in  = ($urandom_range(0, 7) == 0);
        return r;
    endfunction

    function automatic gfrm_pkg::req_t make_request(logic [63:0] src, logic [63:0] dst,
                                                    logic last);
        gfrm_pkg::req_t r;
        r.src_word = src;
        r.dst_word = dst;
        r.last_in  = last;
        return r;
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: w8, multiply by one, overwrite
        send_word(make_request('1, '1, 1'b1));
        send_word(make_request('0, '0, 1'b0));
        drain();

        for (int m = 0; m < 4; m++)
        begin
            configure(gfrm_pkg::mode_t'(m), 32'hffff_ffff, 1'b0);
            send_word(make_request('1, {$urandom, $urandom}, 1'b0));
            send_word(make_request({$urandom, $urandom}, '1, 1'b1));
            drain();
            // zero multiplier while accumulating leaves the destination
            configure(gfrm_pkg::mode_t'(m), 32'd0, 1'b1);
            send_word(make_request({$urandom, $urandom}, '1, 1'b0));
            drain();
        end

        // multiplier bits above the lane width are ignored
        configure(gfrm_pkg::MODE_W4, 32'hffff_fff0, 1'b0);
        send_word(make_request('1, '1, 1'b1));
        drain();
        configure(gfrm_pkg::MODE_W32, 32'h8000_0000, 1'b1);
        send_word(make_request({$urandom, $urandom}, {$urandom, $urandom}, 1'b0));
        drain();
        configure(gfrm_pkg::MODE_W16, 32'd0, 1'b0);
        send_word(make_request({$urandom, $urandom}, '1, 1'b1));
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p >= NUM_PHASES - 2)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            configure(gfrm_pkg::mode_t'($urandom_range(0, 3)), rand_multiplier(),
                      1'($urandom_range(0, 1)));
            if (p == 2)
                hold_request = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 5 && i == 20)
                begin
                    req_valid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending() != 0)
                        @(posedge clk);
                end
                send_word(rand_request());
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
